// ===== src/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared widths, register map and beat layout of the point-in-cone test unit.
// ----------------------------------------------------------------------------
package pic_pkg;

    // Field widths of the streams and the configuration registers.
    localparam int W_POS  = 32;
    localparam int W_DIR  = 16;
    localparam int W_CFG  = 24;
    localparam int W_IN   = 9 * 0 + 6 * W_POS + 3 * W_DIR;
    localparam int W_OUT  = 8;

    // Configuration port.
    localparam int W_ADDR = 4;
    localparam int W_APB  = 32;
    localparam int N_REGS = 3;
    localparam logic [1:0] REG_CONE_LENGTH = 2'd0;
    localparam logic [1:0] REG_CONE_RADIUS = 2'd1;
    localparam logic [1:0] REG_APEX_OFFSET = 2'd2;
    localparam logic [W_CFG-1:0] RST_CONE_LENGTH = 24'd327680;
    localparam logic [W_CFG-1:0] RST_CONE_RADIUS = 24'd131072;
    localparam logic [W_CFG-1:0] RST_APEX_OFFSET = 24'd65536;

    // Datapath widths.
    localparam int W_V    = 34;   // target minus apex, signed
    localparam int W_VM   = 33;   // magnitude of one offset component
    localparam int W_VF   = 50;   // offset times facing, signed
    localparam int W_FF   = 31;   // facing component squared
    localparam int W_VV   = 66;   // offset component squared
    localparam int W_P    = 52;   // projection onto facing, signed
    localparam int W_DD   = 32;   // squared facing length
    localparam int W_V2   = 68;   // squared offset length
    localparam int W_CSQ  = 48;   // squared cone length or radius
    localparam int W_LD   = 56;   // cone length times squared facing length
    localparam int W_DD2  = 64;
    localparam int W_PS   = 42;   // projection width once the axial test passes
    localparam int W_PH   = 21;   // half of that, for the squaring
    localparam int W_P2   = 84;
    localparam int W_T    = 81;
    localparam int W_A    = 116;
    localparam int W_LHS  = 180;
    localparam int W_RHS  = 165;
    localparam int P_SHIFT = 14;  // aligns the projection with the axis scale
    localparam int R_SHIFT = 28;  // aligns the squared radius with the axis scale

    // Pipeline stages: three in the vector front end, seven in the compare.
    localparam int NSTG_VEC = 3;
    localparam int NSTG_CMP = 7;
    localparam int NSTG     = NSTG_VEC + NSTG_CMP;

    typedef logic [NSTG-1:0] t_stage_en;

    typedef struct packed {
        logic [W_CFG-1:0] cone_length;
        logic [W_CFG-1:0] cone_radius;
        logic [W_CFG-1:0] apex_height_offset;
    } t_cfg;

    // Members are listed from the top of the data word down, so that the
    // observer x coordinate lands in the lowest bits.
    typedef struct packed {
        logic signed [W_POS-1:0] target_z;
        logic signed [W_POS-1:0] target_y;
        logic signed [W_POS-1:0] target_x;
        logic signed [W_DIR-1:0] facing_z;
        logic signed [W_DIR-1:0] facing_y;
        logic signed [W_DIR-1:0] facing_x;
        logic signed [W_POS-1:0] observer_z;
        logic signed [W_POS-1:0] observer_y;
        logic signed [W_POS-1:0] observer_x;
    } t_beat;

endpackage

// ===== src/pic_wmul.sv =====
// ----------------------------------------------------------------------------
// pic_wmul
// Three-stage unsigned wide multiplier built from narrow partial products.
// ----------------------------------------------------------------------------
module pic_wmul #(
    parameter int WA = 68,
    parameter int WB = 48,
    parameter int SA = 34,
    parameter int SB = 24
) (
    input  logic              i_clk,
    input  logic [2:0]        i_en,
    input  logic [WA-1:0]     i_a,
    input  logic [WB-1:0]     i_b,
    output logic [WA+WB-1:0]  o_prod
);

    localparam int NA   = (WA + SA - 1) / SA;
    localparam int NB   = (WB + SB - 1) / SB;
    localparam int WPP  = SA + SB;
    localparam int WROW = SA + NB * SB;
    localparam int WSUM = NA * SA + NB * SB;

    logic [NA*SA-1:0]   a_ext;
    logic [NB*SB-1:0]   b_ext;
    logic [WPP-1:0]     n_pp [NA][NB];
    logic [WPP-1:0]     r_pp [NA][NB];
    logic [WROW-1:0]    n_row [NA];
    logic [WROW-1:0]    r_row [NA];
    logic [WSUM-1:0]    n_sum;
    logic [WA+WB-1:0]   r_prod;

    assign a_ext = (NA * SA)'(i_a);
    assign b_ext = (NB * SB)'(i_b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_pp[i][j] = WPP'(a_ext[i*SA +: SA]) * WPP'(b_ext[j*SB +: SB]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (WROW'(r_pp[i][j]) << (j * SB));
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (WSUM'(r_row[i]) << (i * SA));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pp <= n_pp;
        end
        if (i_en[1]) begin
            r_row <= n_row;
        end
        if (i_en[2]) begin
            r_prod <= n_sum[WA+WB-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== src/pic_vec.sv =====
// ----------------------------------------------------------------------------
// pic_vec
// Vector front end: offset from the apex, projection onto the facing
// direction, squared facing length and squared offset length.
// ----------------------------------------------------------------------------
module pic_vec
    import pic_pkg::*;
(
    input  logic                i_clk,
    input  logic [NSTG_VEC-1:0] i_en,
    input  t_beat               i_beat,
    input  logic [W_CFG-1:0]    i_apex_off,
    output logic [W_P-1:0]      o_p,
    output logic [W_DD-1:0]     o_dd,
    output logic [W_V2-1:0]     o_v2
);

    logic [W_V-1:0]      n_s1_v [3];
    logic [W_V-1:0]      r_s1_v [3];
    logic [W_DIR-1:0]    n_s1_f [3];
    logic [W_DIR-1:0]    r_s1_f [3];

    logic [W_VM-1:0]     mag [3];
    logic [2*W_DIR-1:0]  ff_full [3];
    logic [W_VF-1:0]     n_s2_vf [3];
    logic [W_VF-1:0]     r_s2_vf [3];
    logic [W_FF-1:0]     n_s2_ff [3];
    logic [W_FF-1:0]     r_s2_ff [3];
    logic [W_VV-1:0]     n_s2_vv [3];
    logic [W_VV-1:0]     r_s2_vv [3];

    logic [W_P-1:0]      n_s3_p;
    logic [W_P-1:0]      r_s3_p;
    logic [W_DD-1:0]     n_s3_dd;
    logic [W_DD-1:0]     r_s3_dd;
    logic [W_V2-1:0]     n_s3_v2;
    logic [W_V2-1:0]     r_s3_v2;

    function automatic logic [W_V-1:0] sx_pos(input logic [W_POS-1:0] x);
        return {{(W_V-W_POS){x[W_POS-1]}}, x};
    endfunction

    always_comb begin
        n_s1_v[0] = sx_pos(i_beat.target_x) - sx_pos(i_beat.observer_x);
        n_s1_v[1] = sx_pos(i_beat.target_y) - sx_pos(i_beat.observer_y)
                  - {{(W_V-W_CFG){i_apex_off[W_CFG-1]}}, i_apex_off};
        n_s1_v[2] = sx_pos(i_beat.target_z) - sx_pos(i_beat.observer_z);
        n_s1_f[0] = i_beat.facing_x;
        n_s1_f[1] = i_beat.facing_y;
        n_s1_f[2] = i_beat.facing_z;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_vf[k] = {{(W_VF-W_V){r_s1_v[k][W_V-1]}}, r_s1_v[k]}
                       * {{(W_VF-W_DIR){r_s1_f[k][W_DIR-1]}}, r_s1_f[k]};
            ff_full[k] = {{W_DIR{r_s1_f[k][W_DIR-1]}}, r_s1_f[k]}
                       * {{W_DIR{r_s1_f[k][W_DIR-1]}}, r_s1_f[k]};
            n_s2_ff[k] = ff_full[k][W_FF-1:0];
            mag[k]     = r_s1_v[k][W_V-1] ? W_VM'(~r_s1_v[k] + 1'b1) : r_s1_v[k][W_VM-1:0];
            n_s2_vv[k] = {{W_VM{1'b0}}, mag[k]} * {{W_VM{1'b0}}, mag[k]};
        end
    end

    always_comb begin
        n_s3_p  = '0;
        n_s3_dd = '0;
        n_s3_v2 = '0;
        for (int k = 0; k < 3; k++) begin
            n_s3_p  = n_s3_p + {{(W_P-W_VF){r_s2_vf[k][W_VF-1]}}, r_s2_vf[k]};
            n_s3_dd = n_s3_dd + {{(W_DD-W_FF){1'b0}}, r_s2_ff[k]};
            n_s3_v2 = n_s3_v2 + {{(W_V2-W_VV){1'b0}}, r_s2_vv[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_v <= n_s1_v;
            r_s1_f <= n_s1_f;
        end
        if (i_en[1]) begin
            r_s2_vf <= n_s2_vf;
            r_s2_ff <= n_s2_ff;
            r_s2_vv <= n_s2_vv;
        end
        if (i_en[2]) begin
            r_s3_p  <= n_s3_p;
            r_s3_dd <= n_s3_dd;
            r_s3_v2 <= n_s3_v2;
        end
    end

    assign o_p  = r_s3_p;
    assign o_dd = r_s3_dd;
    assign o_v2 = r_s3_v2;

endmodule

// ===== src/pic_cmp.sv =====
// ----------------------------------------------------------------------------
// pic_cmp
// Axial range test and the root-free angle test on wide products.
// ----------------------------------------------------------------------------
module pic_cmp
    import pic_pkg::*;
(
    input  logic                i_clk,
    input  logic [NSTG_CMP-1:0] i_en,
    input  logic [W_CFG-1:0]    i_cone_len,
    input  logic [W_CFG-1:0]    i_cone_rad,
    input  logic [W_P-1:0]      i_p,
    input  logic [W_DD-1:0]     i_dd,
    input  logic [W_V2-1:0]     i_v2,
    output logic                o_hit
);

    logic [W_CSQ-1:0]   r_len_sq;
    logic [W_CSQ-1:0]   r_rad_sq;

    logic [W_PH-1:0]    p_lo;
    logic [W_PH-1:0]    p_hi;

    logic [W_LD-1:0]    r_s4_ld;
    logic [W_DD2-1:0]   r_s4_dd2;
    logic               r_s4_pneg;
    logic [W_P-2:0]     r_s4_pmag;
    logic               r_s4_zero;
    logic [2*W_PH-1:0]  r_s4_pll;
    logic [2*W_PH-1:0]  r_s4_plh;
    logic [2*W_PH-1:0]  r_s4_phh;
    logic [W_LD-1:0]    r_s4_tlo;
    logic [W_LD-1:0]    r_s4_thi;

    logic               n_s5_ax;
    logic               r_s5_ax;
    logic [W_P2-1:0]    n_s5_p2;
    logic [W_P2-1:0]    r_s5_p2;
    logic [W_T-1:0]     n_s5_t;
    logic [W_T-1:0]     r_s5_t;
    logic [W_DD2-1:0]   r_s5_dd2;

    logic [W_DD2-1:0]   r_s6_dd2;
    logic               r_s6_ax;
    logic               r_s7_ax;
    logic               r_s8_ax;
    logic               r_s9_ax;
    logic [W_RHS-1:0]   r_s9_rhs;
    logic               r_s10_hit;

    logic [W_A-1:0]     prod_a;
    logic [W_LHS-1:0]   prod_lhs;
    logic [W_RHS-1:0]   prod_rhs;

    // The cone settings must only change while no beat is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        r_len_sq <= {{W_CFG{1'b0}}, i_cone_len} * {{W_CFG{1'b0}}, i_cone_len};
        r_rad_sq <= {{W_CFG{1'b0}}, i_cone_rad} * {{W_CFG{1'b0}}, i_cone_rad};
    end

    assign p_lo = i_p[W_PH-1:0];
    assign p_hi = i_p[W_PS-1:W_PH];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4_ld   <= {{W_DD{1'b0}}, i_cone_len} * {{W_CFG{1'b0}}, i_dd};
            r_s4_dd2  <= {{W_DD{1'b0}}, i_dd} * {{W_DD{1'b0}}, i_dd};
            r_s4_pneg <= i_p[W_P-1];
            r_s4_pmag <= i_p[W_P-2:0];
            r_s4_zero <= (i_cone_len == '0) || (i_dd == '0);
            r_s4_pll  <= {{W_PH{1'b0}}, p_lo} * {{W_PH{1'b0}}, p_lo};
            r_s4_plh  <= {{W_PH{1'b0}}, p_lo} * {{W_PH{1'b0}}, p_hi};
            r_s4_phh  <= {{W_PH{1'b0}}, p_hi} * {{W_PH{1'b0}}, p_hi};
            r_s4_tlo  <= {{W_DD{1'b0}}, r_len_sq[W_CFG-1:0]} * {{W_CFG{1'b0}}, i_dd};
            r_s4_thi  <= {{W_DD{1'b0}}, r_len_sq[W_CSQ-1:W_CFG]} * {{W_CFG{1'b0}}, i_dd};
        end
    end

    always_comb begin
        n_s5_ax = !r_s4_zero && !r_s4_pneg
               && ({r_s4_pmag, {P_SHIFT{1'b0}}}
                   <= {{(W_P-1+P_SHIFT-W_LD){1'b0}}, r_s4_ld});
        n_s5_p2 = {{(W_P2-2*W_PH){1'b0}}, r_s4_pll}
                + {{(W_P2-3*W_PH-1){1'b0}}, r_s4_plh, {(W_PH+1){1'b0}}}
                + {r_s4_phh, {(2*W_PH){1'b0}}};
        n_s5_t  = {{(W_T-W_LD){1'b0}}, r_s4_tlo}
                + {{(W_T-W_LD-W_CFG){1'b0}}, r_s4_thi, {W_CFG{1'b0}}}
                + {{(W_T-W_CSQ-R_SHIFT){1'b0}}, r_rad_sq, {R_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s5_ax  <= n_s5_ax;
            r_s5_p2  <= n_s5_p2;
            r_s5_t   <= n_s5_t;
            r_s5_dd2 <= r_s4_dd2;
        end
        if (i_en[2]) begin
            r_s6_dd2 <= r_s5_dd2;
            r_s6_ax  <= r_s5_ax;
        end
        if (i_en[3]) begin
            r_s7_ax <= r_s6_ax;
        end
        if (i_en[4]) begin
            r_s8_ax <= r_s7_ax;
        end
        if (i_en[5]) begin
            r_s9_ax  <= r_s8_ax;
            r_s9_rhs <= prod_rhs;
        end
        if (i_en[6]) begin
            r_s10_hit <= r_s9_ax && (prod_lhs <= {{(W_LHS-W_RHS){1'b0}}, r_s9_rhs});
        end
    end

    pic_wmul #(.WA(W_V2), .WB(W_CSQ), .SA(34), .SB(24)) u_mul_vl (
        .i_clk  (i_clk),
        .i_en   (i_en[2:0]),
        .i_a    (i_v2),
        .i_b    (r_len_sq),
        .o_prod (prod_a)
    );

    pic_wmul #(.WA(W_A), .WB(W_DD2), .SA(29), .SB(32)) u_mul_lhs (
        .i_clk  (i_clk),
        .i_en   (i_en[5:3]),
        .i_a    (prod_a),
        .i_b    (r_s6_dd2),
        .o_prod (prod_lhs)
    );

    pic_wmul #(.WA(W_P2), .WB(W_T), .SA(28), .SB(27)) u_mul_rhs (
        .i_clk  (i_clk),
        .i_en   (i_en[4:2]),
        .i_a    (r_s5_p2),
        .i_b    (r_s5_t),
        .o_prod (prod_rhs)
    );

    assign o_hit = r_s10_hit;

endmodule

// ===== src/point_in_cone_test_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_cone_test_unit
// Tests whether a target lies inside a view cone placed at an observer.
// ----------------------------------------------------------------------------
// The input stream carries one query per beat: observer position, facing
// direction and target position. The output stream returns one beat per
// query, in order, with the inside flag in bit 0.
// The cone length, cone radius and apex height offset are set through the
// APB port and must only be written while no query is in flight.
// The datapath is a ten-stage pipeline that takes one beat per cycle while
// the receiver does not stall it; its depth is set by the wide products of
// the angle test.
// Reset loads the default cone settings and empties the pipeline.
// When the receiver stalls, the last stage holds its beat and the stages
// behind it hold as well, while empty stages keep filling, so input beats
// are taken until all ten stages are occupied. Nothing is dropped.
// ----------------------------------------------------------------------------
module point_in_cone_test_unit
    import pic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // observer_x, observer_y, observer_z, facing_x, facing_y, facing_z,
    // target_x, target_y, target_z
    input  logic [W_IN-1:0]   i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // inside_cone, then zero padding
    output logic [W_OUT-1:0]  o_m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [W_ADDR-1:0] paddr,
    input  logic [W_APB-1:0]  pwdata,
    output logic [W_APB-1:0]  prdata,
    output logic              pready
);

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic               cfg_wr;
    t_stage_en          en;
    t_stage_en          r_vld;
    t_stage_en          n_vld;
    t_beat              beat;
    logic [W_P-1:0]     vec_p;
    logic [W_DD-1:0]    vec_dd;
    logic [W_V2-1:0]    vec_v2;
    logic               hit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (paddr[W_ADDR-1:2])
                REG_CONE_LENGTH: n_cfg.cone_length        = pwdata[W_CFG-1:0];
                REG_CONE_RADIUS: n_cfg.cone_radius        = pwdata[W_CFG-1:0];
                REG_APEX_OFFSET: n_cfg.apex_height_offset = pwdata[W_CFG-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cone_length        <= RST_CONE_LENGTH;
            r_cfg.cone_radius        <= RST_CONE_RADIUS;
            r_cfg.apex_height_offset <= RST_APEX_OFFSET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[W_ADDR-1:2])
            REG_CONE_LENGTH: prdata = {{(W_APB-W_CFG){1'b0}}, r_cfg.cone_length};
            REG_CONE_RADIUS: prdata = {{(W_APB-W_CFG){1'b0}}, r_cfg.cone_radius};
            REG_APEX_OFFSET: prdata = {{(W_APB-W_CFG){1'b0}}, r_cfg.apex_height_offset};
            default:         prdata = '0;
        endcase
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_s_tvalid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign beat = t_beat'(i_s_tdata);

    pic_vec u_vec (
        .i_clk      (i_clk),
        .i_en       (en[NSTG_VEC-1:0]),
        .i_beat     (beat),
        .i_apex_off (r_cfg.apex_height_offset),
        .o_p        (vec_p),
        .o_dd       (vec_dd),
        .o_v2       (vec_v2)
    );

    pic_cmp u_cmp (
        .i_clk      (i_clk),
        .i_en       (en[NSTG-1:NSTG_VEC]),
        .i_cone_len (r_cfg.cone_length),
        .i_cone_rad (r_cfg.cone_radius),
        .i_p        (vec_p),
        .i_dd       (vec_dd),
        .i_v2       (vec_v2),
        .o_hit      (hit)
    );

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {{(W_OUT-1){1'b0}}, hit};

endmodule

// ===== src/pic_checker.sv =====
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks of the point-in-cone test unit, bound to the top level.
// ----------------------------------------------------------------------------
module pic_checker
    import pic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_s_tready,
    input  logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  logic [W_OUT-1:0]  o_m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [W_ADDR-1:0] paddr,
    input  logic [W_APB-1:0]  pwdata,
    input  logic [W_APB-1:0]  prdata,
    input  logic              pready
);

    // Reset empties the pipeline and opens the input.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("pipeline not empty after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // The input is only held back while a result beat waits at the output.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with an empty output");

    // A written register reads back its value.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (int'(paddr[W_ADDR-1:2]) < N_REGS))
        ##1 (psel && !pwrite && (paddr == $past(paddr)))
        |-> prdata[W_CFG-1:0] == $past(pwdata[W_CFG-1:0]))
        else $error("register read back differs from written value");

endmodule

bind point_in_cone_test_unit pic_checker u_pic_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);
